FILE: hw/rtl/mvb_pkg.sv
package mvb_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int DEF_MAX_SAMPLES = 64;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] median_value;
    logic                          overflowed;
  } result_t;

  typedef struct packed {
    logic load;    // sample transfer on the input channel
    logic init;    // start a pass: form guess, clear pass registers
    logic scan;    // issue one store read
    logic narrow;  // move one bound after a pass that did not converge
    logic finish;  // load result register, start a new set
  } mvb_cmd_t;

  typedef struct packed {
    logic scan_last;  // current read address is the last stored sample
    logic converged;  // neither side of the guess holds more than half
    logic out_free;   // result register can take a new result
  } mvb_stat_t;

endpackage

FILE: hw/rtl/median_value_bisection.sv
// Loading: one sample transfer per cycle; the set ends at the sample marked last.
// Search: passes of pass setup, store reads (one per stored sample), read drain
// and evaluation; passes repeat until the bounds converge.
// Result: registered after the final pass, held in an output register; the next
// set is taken while it waits. Throughput is set by the single store read port.
// Reset (rst, synchronous): empty set, no result pending, ready for samples.
module median_value_bisection
  import mvb_pkg::*;
#(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  mvb_cmd_t  cmd;
  mvb_stat_t stat;

  mvb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .last_sample (item.last_sample),
    .stat        (stat),
    .item_ready  (item_ready),
    .cmd         (cmd)
  );

  mvb_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .result_ready (result_ready),
    .stat         (stat),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

FILE: hw/rtl/mvb_ctrl.sv
module mvb_ctrl
  import mvb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  logic      last_sample,
  input  mvb_stat_t stat,
  output logic      item_ready,
  output mvb_cmd_t  cmd
);

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_INIT   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_EVAL   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  assign item_ready = (state == S_LOAD);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_LOAD: begin
        if (item_valid) begin
          cmd.load = 1'b1;
          if (last_sample) begin
            state_next = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (stat.converged) begin
          state_next = S_FINISH;
        end else begin
          cmd.narrow = 1'b1;
          state_next = S_INIT;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

FILE: hw/rtl/mvb_dp.sv
module mvb_dp
  import mvb_pkg::*;
#(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
  input  logic      clk,
  input  logic      rst,
  input  item_t     item,
  input  mvb_cmd_t  cmd,
  input  logic      result_ready,
  output mvb_stat_t stat,
  output logic      result_valid,
  output result_t   result
);

  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_SAMPLES);

  logic signed [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic                          rd_valid;
  logic [AW-1:0]                 addr;

  logic [CW-1:0]                 count;
  logic                          drop;
  logic signed [SAMPLE_BITS-1:0] lower_bound;
  logic signed [SAMPLE_BITS-1:0] upper_bound;
  logic signed [SAMPLE_BITS-1:0] guess;
  logic [CW-1:0]                 below_count;
  logic [CW-1:0]                 above_count;
  logic [CW-1:0]                 equal_count;
  logic signed [SAMPLE_BITS-1:0] largest_below;
  logic signed [SAMPLE_BITS-1:0] smallest_above;

  logic                          full;
  logic [CW-1:0]                 last_addr;
  logic [CW:0]                   count_inc;
  logic [CW-1:0]                 half;
  logic [CW:0]                   below_equal;
  logic signed [SAMPLE_BITS:0]   bound_sum;
  logic signed [SAMPLE_BITS-1:0] median;

  assign full        = (count == FULL);
  assign last_addr   = count - CW'(1);
  assign count_inc   = {1'b0, count} + (CW+1)'(1);
  assign half        = CW'(count_inc >> 1);
  assign below_equal = {1'b0, below_count} + {1'b0, equal_count};
  assign bound_sum   = {lower_bound[SAMPLE_BITS-1], lower_bound}
                     + {upper_bound[SAMPLE_BITS-1], upper_bound};

  always_comb begin
    if (below_count >= half) begin
      median = largest_below;
    end else if (below_equal >= {1'b0, half}) begin
      median = guess;
    end else begin
      median = smallest_above;
    end
  end

  assign stat.scan_last = (addr == last_addr[AW-1:0]);
  assign stat.converged = (below_count <= half) && (above_count <= half);
  assign stat.out_free  = !result_valid || result_ready;

  // sample store
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[count[AW-1:0]] <= item.sample;
    end
    rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      drop         <= 1'b0;
      rd_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.scan;
      if (cmd.finish) begin
        count <= '0;
        drop  <= 1'b0;
      end else if (cmd.load) begin
        if (full) begin
          drop <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
      end
      if (cmd.finish) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      if (count == '0) begin
        lower_bound <= item.sample;
        upper_bound <= item.sample;
      end else begin
        if (item.sample < lower_bound) lower_bound <= item.sample;
        if (item.sample > upper_bound) upper_bound <= item.sample;
      end
    end else if (cmd.narrow) begin
      if (below_count > above_count) begin
        upper_bound <= largest_below;
      end else begin
        lower_bound <= smallest_above;
      end
    end

    if (cmd.init) begin
      guess          <= bound_sum[SAMPLE_BITS:1];
      below_count    <= '0;
      above_count    <= '0;
      equal_count    <= '0;
      largest_below  <= lower_bound;
      smallest_above <= upper_bound;
      addr           <= '0;
    end else begin
      if (cmd.scan) begin
        addr <= addr + AW'(1);
      end
      if (rd_valid) begin
        if (rd_data < guess) begin
          below_count <= below_count + CW'(1);
          if (rd_data > largest_below) largest_below <= rd_data;
        end else if (rd_data > guess) begin
          above_count <= above_count + CW'(1);
          if (rd_data < smallest_above) smallest_above <= rd_data;
        end else begin
          equal_count <= equal_count + CW'(1);
        end
      end
    end

    if (cmd.finish) begin
      result.median_value <= median;
      result.overflowed   <= drop;
    end
  end

endmodule

FILE: hw/rtl/mvb_checker.sv
module mvb_checker
  import mvb_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input item_t   item,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  a_reset_state: assert property (@(posedge clk)
    $past(rst) |-> item_ready && !result_valid)
    else $error("not ready for samples after reset");

  a_last_stops_load: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.last_sample |=> !item_ready)
    else $error("sample transfer taken after end of set");

  a_result_on_load: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> item_ready)
    else $error("result appeared outside the load phase");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("pending result dropped or changed");

endmodule

bind median_value_bisection mvb_checker u_mvb_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

FILE: verif/median_value_bisection_checker.sv
module median_value_bisection_checker
  import mvb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_ready,
  input  item_t   item,
  input  logic    result_valid,
  input  logic    result_ready,
  input  result_t result,
  output int      fail_count,
  output int      pending
);

  localparam int STORE_DEPTH = DEF_MAX_SAMPLES;

  int      median_store [STORE_DEPTH];
  int      stored_count;
  int      low_bound;
  int      high_bound;
  bit      set_dropped;
  result_t median_expected [$];

  function automatic result_t bisect_median();
    int      n;
    int      half;
    int      lo;
    int      hi;
    int      guess;
    int      nb;
    int      na;
    int      ne;
    int      lb;
    int      sa;
    int      v;
    int      med;
    int      pass;
    int      i;
    result_t r;
    n = stored_count;
    half = (n + 1) / 2;
    lo = low_bound;
    hi = high_bound;
    guess = 0;
    nb = 0;
    na = 0;
    ne = 0;
    lb = lo;
    sa = hi;
    for (pass = 0; pass < 100000; pass++) begin
      guess = (lo + hi) >>> 1;
      nb = 0;
      na = 0;
      ne = 0;
      lb = lo;
      sa = hi;
      for (i = 0; i < n; i++) begin
        v = median_store[i];
        if (v < guess) begin
          nb++;
          if (v > lb) lb = v;
        end else if (v > guess) begin
          na++;
          if (v < sa) sa = v;
        end else begin
          ne++;
        end
      end
      if (nb <= half && na <= half) break;
      if (nb > na) hi = lb;
      else lo = sa;
    end
    if (nb >= half) med = lb;
    else if (nb + ne >= half) med = guess;
    else med = sa;
    r.median_value = med[SAMPLE_BITS-1:0];
    r.overflowed = set_dropped;
    return r;
  endfunction

  task automatic absorb_sample(input item_t it);
    int s;
    s = $signed(it.sample);
    if (stored_count < STORE_DEPTH) begin
      if (stored_count == 0) begin
        low_bound = s;
        high_bound = s;
      end else begin
        if (s < low_bound) low_bound = s;
        if (s > high_bound) high_bound = s;
      end
      median_store[stored_count] = s;
      stored_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (it.last_sample) begin
      median_expected.push_back(bisect_median());
      stored_count = 0;
      set_dropped = 1'b0;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    stored_count = 0;
    low_bound = 0;
    high_bound = 0;
    set_dropped = 1'b0;
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      stored_count = 0;
      set_dropped = 1'b0;
      median_expected.delete();
    end else begin
      if (item_valid && item_ready) absorb_sample(item);
      if (result_valid && result_ready) begin
        if (median_expected.size() == 0) begin
          $error("result transfer with no median pending");
          fail_count++;
        end else begin
          want = median_expected.pop_front();
          if (result.median_value !== want.median_value) begin
            $error("median_value: expected %0d, got %0d",
                   $signed(want.median_value), $signed(result.median_value));
            fail_count++;
          end
          if (result.overflowed !== want.overflowed) begin
            $error("overflowed: expected %0d, got %0d",
                   want.overflowed, result.overflowed);
            fail_count++;
          end
        end
      end
    end
    pending = median_expected.size();
  end

endmodule

FILE: verif/median_value_bisection_tb.sv
module median_value_bisection_tb;
  import mvb_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_TARGET = 1750;

  logic    clk = 1'b0;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;
  int      fail_count;
  int      pending;
  int      cycle_count = 0;

  median_value_bisection DUT (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  median_value_bisection_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** median_value_bisection: FAILED **");
      $finish;
    end
  end

  function automatic int pick_gap(input bit calm);
    if (calm) return 0;
    return $urandom_range(0, 10);
  endfunction

  int items_sent = 0;

  task automatic send_set(input int vals[$], input bit calm);
    int    gap;
    int    k;
    item_t it;
    for (k = 0; k < vals.size(); k++) begin
      gap = pick_gap(calm);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      it.sample = vals[k][SAMPLE_BITS-1:0];
      it.last_sample = (k == vals.size() - 1);
      item_valid <= 1'b1;
      item <= it;
      do @(posedge clk); while (!item_ready);
      @(negedge clk);
      items_sent++;
    end
  endtask

  task automatic drain_results();
    int gap;
    bit calm;
    calm = 1'b0;
    forever begin
      if ($urandom_range(0, 5) == 0) calm = !calm;
      gap = pick_gap(calm);
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      @(negedge clk);
    end
  endtask

  initial begin
    int vals[$];
    int sz;
    int mode;
    int center;
    int r;
    int k;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    fork
      drain_results();
    join_none

    // extremes, pairs straddling zero, ties, odd and even sizes
    send_set('{32767}, 1'b0);
    send_set('{-32768}, 1'b0);
    send_set('{-32768, 32767}, 1'b0);
    send_set('{0, -1}, 1'b1);
    send_set('{5, 5, 5}, 1'b0);
    send_set('{-1, 0, 1, -2}, 1'b0);
    send_set('{3, -7, 3, 100, -7}, 1'b1);
    send_set('{32767, 32767, -32768}, 1'b0);

    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 9);
      if (r < 6) sz = $urandom_range(1, 12);
      else if (r < 9) sz = $urandom_range(13, 63);
      else sz = $urandom_range(64, 72);
      mode = $urandom_range(0, 3);
      center = int'($urandom_range(0, 64000)) - 32000;
      vals.delete();
      for (k = 0; k < sz; k++) begin
        case (mode)
          0: vals.push_back(int'($urandom_range(0, 65535)) - 32768);
          1: vals.push_back(int'($urandom_range(0, 8)) - 4);
          2: begin
            case ($urandom_range(0, 3))
              0: vals.push_back(-32768);
              1: vals.push_back(32767);
              2: vals.push_back(-1);
              default: vals.push_back(0);
            endcase
          end
          default: vals.push_back(center + int'($urandom_range(0, 200)) - 100);
        endcase
      end
      send_set(vals, $urandom_range(0, 4) == 0);
    end
    item_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (fail_count == 0) begin
      $display("** median_value_bisection: PASSED **");
    end else begin
      $display("** median_value_bisection: FAILED **");
    end
    $finish;
  end

endmodule
